// ===== design/atsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsp_pkg
// shared widths, constants and controller/datapath interface types for the
// shelf tile packer
// ----------------------------------------------------------------------------
package atsp_pkg;

	localparam int NUM_BANDS = 16;
	localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
	localparam int CNT_W     = $clog2(NUM_BANDS + 1);
	localparam int IDX_W     = CNT_W + 1;

	localparam int SIZE_W  = 13;
	localparam int CFG_W   = 13;
	localparam int COORD_W = 16;
	localparam int OFF_W   = SIZE_W + 1;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 3 * COORD_W;

	localparam logic [CFG_W-1:0]   RESET_HEIGHT = 13'd512;
	localparam logic [CFG_W-1:0]   RESET_BAND   = 13'd32;
	localparam logic [COORD_W-1:0] COORD_MAX    = 16'hFFFF;

	// configuration register indexes
	localparam logic REG_ATLAS_HEIGHT = 1'b0;
	localparam logic REG_BAND_SIZE    = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CHECK,
		OP_MAX,
		OP_POS,
		OP_DIV,
		OP_UPD,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic new_col;
		logic scan_end;
		logic cnt_full;
		logic div_done;
		logic idx_beyond;
	} dp_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MAX,
		ST_POS,
		ST_DIV,
		ST_UPD,
		ST_FIN,
		ST_WAIT
	} ctrl_state_t;

endpackage

// ===== design/atsp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsp_dp
// datapath: configuration registers, atlas state, band offset store, scan
// counters, band index divider and the output register
// ----------------------------------------------------------------------------
module atsp_dp
	import atsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic                   in_tuser,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts,
	output logic [OUT_TDATA_W-1:0] out_tdata,
	output logic                   out_tuser
);

	logic [CFG_W-1:0]   atlas_height_q;
	logic [CFG_W-1:0]   band_size_q;
	logic [COORD_W-1:0] column_x_q;
	logic [COORD_W-1:0] row_y_q;
	logic [COORD_W-1:0] width_so_far_q;
	logic [COORD_W-1:0] band_q [NUM_BANDS];

	logic [SIZE_W-1:0]  size_q;
	logic [OFF_W-1:0]   off_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   base_q;
	logic [COORD_W-1:0] r_q;
	logic [COORD_W-1:0] maxoff_q;
	logic               ovf_q;
	logic [COORD_W-1:0] res_x_q;
	logic [COORD_W-1:0] res_y_q;
	logic [COORD_W-1:0] res_width_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic               out_tuser_q;

	logic [CFG_W-1:0]   bsz;
	logic [IDX_W-1:0]   upd_idx;
	logic [BAND_W-1:0]  rd_idx;
	logic [COORD_W-1:0] band_rd;
	logic [COORD_W:0]   band_sum;
	logic [COORD_W-1:0] band_new;
	logic [COORD_W:0]   end_sum;
	logic [COORD_W-1:0] end_sat;
	logic [COORD_W-1:0] width_new;
	logic [COORD_W:0]   row_sum;
	logic [COORD_W-1:0] row_new;

	// a band size of zero behaves as one
	assign bsz = (band_size_q == '0) ? CFG_W'(1) : band_size_q;

	assign upd_idx = IDX_W'(base_q) + IDX_W'(k_q);
	assign rd_idx  = (cmd.op == OP_UPD) ? upd_idx[BAND_W-1:0] : k_q[BAND_W-1:0];
	assign band_rd = band_q[rd_idx];

	assign band_sum = {1'b0, band_rd} + (COORD_W+1)'(size_q);
	assign band_new = band_sum[COORD_W] ? COORD_MAX : band_sum[COORD_W-1:0];

	assign end_sum   = {1'b0, column_x_q} + (COORD_W+1)'(size_q);
	assign end_sat   = end_sum[COORD_W] ? COORD_MAX : end_sum[COORD_W-1:0];
	assign width_new = (end_sat > width_so_far_q) ? end_sat : width_so_far_q;

	assign row_sum = {1'b0, row_y_q} + (COORD_W+1)'(size_q);
	assign row_new = row_sum[COORD_W] ? COORD_MAX : row_sum[COORD_W-1:0];

	assign sts.new_col    = row_sum > (COORD_W+1)'(atlas_height_q);
	assign sts.scan_end   = off_q >= OFF_W'(size_q);
	assign sts.cnt_full   = k_q == CNT_W'(NUM_BANDS);
	assign sts.div_done   = (r_q < COORD_W'(bsz)) || (base_q == CNT_W'(NUM_BANDS));
	assign sts.idx_beyond = upd_idx >= IDX_W'(NUM_BANDS);

	// configuration and atlas state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_height_q <= RESET_HEIGHT;
			band_size_q    <= RESET_BAND;
			column_x_q     <= COORD_W'(RESET_HEIGHT);
			row_y_q        <= '0;
			width_so_far_q <= '0;
			for (int i = 0; i < NUM_BANDS; i++) begin
				band_q[i] <= COORD_W'(RESET_HEIGHT);
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_ATLAS_HEIGHT: atlas_height_q <= cfg_wdata;
					REG_BAND_SIZE:    band_size_q    <= cfg_wdata;
					default:          ;
				endcase
			end
			unique case (cmd.op)
				OP_LOAD: begin
					if (in_tuser) begin
						column_x_q     <= COORD_W'(atlas_height_q);
						row_y_q        <= '0;
						width_so_far_q <= '0;
						for (int i = 0; i < NUM_BANDS; i++) begin
							band_q[i] <= COORD_W'(atlas_height_q);
						end
					end
				end
				OP_CHECK: begin
					if (sts.new_col) begin
						row_y_q <= '0;
					end
				end
				OP_MAX: begin
					if (sts.scan_end || sts.cnt_full) begin
						column_x_q <= maxoff_q;
					end
				end
				OP_POS: begin
					width_so_far_q <= width_new;
				end
				OP_UPD: begin
					if (!sts.scan_end && !sts.idx_beyond) begin
						band_q[rd_idx] <= band_new;
					end
				end
				OP_FIN: begin
					row_y_q <= row_new;
				end
				OP_NONE, OP_DIV: ;
				default: ;
			endcase
		end
	end

	// per-tile working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				size_q <= in_tdata[SIZE_W-1:0];
				ovf_q  <= 1'b0;
			end
			OP_CHECK: begin
				off_q    <= '0;
				k_q      <= '0;
				maxoff_q <= '0;
			end
			OP_MAX: begin
				if (sts.scan_end) begin
				end else if (sts.cnt_full) begin
					// bands past the store are left out of the maximum
					ovf_q <= 1'b1;
				end else begin
					if (band_rd > maxoff_q) begin
						maxoff_q <= band_rd;
					end
					k_q   <= k_q + CNT_W'(1);
					off_q <= off_q + OFF_W'(bsz);
				end
			end
			OP_POS: begin
				res_x_q     <= column_x_q;
				res_y_q     <= row_y_q;
				res_width_q <= width_new;
				r_q         <= row_y_q;
				base_q      <= '0;
			end
			OP_DIV: begin
				// first band under the tile: row_y / band size, capped at the store depth
				if (sts.div_done) begin
					k_q   <= '0;
					off_q <= '0;
				end else begin
					r_q    <= r_q - COORD_W'(bsz);
					base_q <= base_q + CNT_W'(1);
				end
			end
			OP_UPD: begin
				if (sts.scan_end) begin
				end else if (sts.idx_beyond) begin
					ovf_q <= 1'b1;
				end else begin
					k_q   <= k_q + CNT_W'(1);
					off_q <= off_q + OFF_W'(bsz);
				end
			end
			OP_NONE, OP_FIN: ;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_tdata_q <= {res_width_q, res_y_q, res_x_q};
			out_tuser_q <= ovf_q;
		end
	end

	assign out_tdata = out_tdata_q;
	assign out_tuser = out_tuser_q;

endmodule

// ===== design/atsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsp_ctrl
// controller: sequences a tile through check, column maximum if new column,
// position, band index, band update and row update, and owns both handshakes
// ----------------------------------------------------------------------------
module atsp_ctrl
	import atsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_tvalid,
	output logic    in_tready,
	output logic    out_tvalid,
	input  logic    out_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;
	logic        out_free;
	logic        accept;

	assign out_free = !out_valid_q || out_tready;
	assign accept   = in_tvalid && in_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_tvalid) state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = sts.new_col ? ST_MAX : ST_POS;
			ST_MAX:   if (sts.scan_end || sts.cnt_full) state_nxt = ST_POS;
			ST_POS:   state_nxt = ST_DIV;
			ST_DIV:   if (sts.div_done) state_nxt = ST_UPD;
			ST_UPD:   if (sts.scan_end || sts.idx_beyond) state_nxt = ST_FIN;
			ST_FIN:   state_nxt = ST_WAIT;
			ST_WAIT:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_tready    = 1'b0;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) cmd.op = OP_LOAD;
			end
			ST_CHECK: cmd.op = OP_CHECK;
			ST_MAX:   cmd.op = OP_MAX;
			ST_POS:   cmd.op = OP_POS;
			ST_DIV:   cmd.op = OP_DIV;
			ST_UPD:   cmd.op = OP_UPD;
			ST_FIN:   cmd.op = OP_FIN;
			ST_WAIT:  cmd.out_load = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_tvalid = out_valid_q;

`ifndef ASSERT_OFF
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_tready))
		else $error("result loaded over an untaken result");

	a_accept_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CHECK))
		else $error("accepted tile did not start its placement");

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (out_tvalid && state_q == ST_IDLE))
		else $error("loaded result not presented");

	a_fin_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (state_q == ST_WAIT))
		else $error("row update not followed by result hand-off");
`endif

endmodule

// ===== design/atlas_shelf_tile_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlas_shelf_tile_packer
// places square tiles into columns of a fixed-height atlas, tracking the fill
// offset of each horizontal band
// ----------------------------------------------------------------------------
// One tile is in work at a time; its placement runs through check, the column
// maximum over min(n, NUM_BANDS) bands if a new column starts, position, the
// band index min(row / band, NUM_BANDS), the update of up to min(n, NUM_BANDS)
// bands and the row update, n being tile_size / band_size rounded up. A new
// column always starts at row 0. Placement time is set by the band offset
// store, which is visited one band per cycle for the column maximum and again
// for the offset update, and by the subtract-per-cycle band index unit.
// A finished result sits in the output register while the next tile is taken;
// a stalled output holds the block only at the end of the following tile.
// Restart (first_tile in tuser) reloads the bands from atlas_height in the
// accept cycle.
module atlas_shelf_tile_packer
	import atsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // tile_size[12:0], zero pad
	input  logic                   s_axis_tuser,  // first_tile
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pos_x, pos_y, atlas_width
	output logic                   m_axis_tuser   // band_overflow
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	atsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tvalid  (s_axis_tvalid),
		.in_tready  (s_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	atsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_tdata (m_axis_tdata),
		.out_tuser (m_axis_tuser)
	);

endmodule
